// ----- src/double_ended_queue_defines.svh -----
// assertion macros for the double ended queue
// no dependencies; included by the top level only
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// property checked at every clock edge outside reset
`define DQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence checked in the cycle after the antecedent
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/dq_pkg.sv -----
// shared types and codes for the double ended queue
// used by dq_cell and double_ended_queue
package dq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed port widths
  localparam int CMD_W   = 2;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // at most one shift/load control set, broadcast to every cell
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } dq_cell_ctl_t;

endpackage

// ----- src/dq_cell.sv -----
// one storage cell of the deque row: a data word and an occupied flag
// depends on dq_pkg for the control struct
module dq_cell #(
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dq_pkg::dq_cell_ctl_t  ctl,
  input  logic [DATA_WIDTH-1:0] push_word,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic                  left_occ,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic                  right_occ,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  occ_o,
  output logic                  tail_o
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  occ_r;
  logic                  occ_nxt;

  always_comb begin
    data_nxt = data_r;
    occ_nxt  = occ_r;
    priority if (ctl.push_front) begin
      data_nxt = left_data;
      occ_nxt  = left_occ;
    end else if (ctl.pop_front) begin
      data_nxt = right_data;
      occ_nxt  = right_occ;
    end else if (ctl.push_back) begin
      // first free cell after the last occupied one takes the word
      if (!occ_r && left_occ) begin
        data_nxt = push_word;
        occ_nxt  = 1'b1;
      end
    end else if (ctl.pop_back) begin
      if (occ_r && !right_occ) begin
        occ_nxt = 1'b0;
      end
    end else begin
      // idle cycle or refused transaction: hold
      data_nxt = data_r;
      occ_nxt  = occ_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign occ_o  = occ_r;
  assign tail_o = occ_r & ~right_occ;

endmodule

// ----- src/double_ended_queue.sv -----
// double ended queue as a row of DEPTH cells; front entry always in cell 0
// the result is registered and valid in the cycle after the transaction is accepted
// throughput: one transaction per cycle unless a waiting result is not taken
// the output register frees up for a new transaction while its result is taken
// reset clears the occupied flags, the count and the output valid; no clearing pass
// depends on dq_pkg, dq_cell and double_ended_queue_defines.svh
`include "double_ended_queue_defines.svh"

module double_ended_queue #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [dq_pkg::CMD_W-1:0]  in_command,
  input  logic [dq_pkg::WORD_W-1:0] in_push_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [dq_pkg::WORD_W-1:0] out_pop_value,
  output logic [dq_pkg::STAT_W-1:0] out_status,
  output logic [dq_pkg::OCC_W-1:0]  out_occupancy
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                      in_fire;
  logic [DATA_WIDTH-1:0]     push_word;
  dq_pkg::dq_cell_ctl_t      ctl;
  logic [DEPTH-1:0]          cell_occ;
  logic [DEPTH-1:0]          cell_tail;
  logic [DATA_WIDTH-1:0]     cell_data [DEPTH];
  logic [DATA_WIDTH-1:0]     tail_word;
  logic [DATA_WIDTH-1:0]     pop_word;
  logic [dq_pkg::WORD_W-1:0] pop_value_c;
  logic [dq_pkg::OCC_W-1:0]  occ_c;
  logic [dq_pkg::STAT_W-1:0] status_c;
  logic                      full;
  logic                      empty;

  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic                      out_valid_r;
  logic [dq_pkg::WORD_W-1:0] out_pop_value_r;
  logic [dq_pkg::STAT_W-1:0] out_status_r;
  logic [dq_pkg::OCC_W-1:0]  out_occupancy_r;

  assign in_ready = ~out_valid_r | out_ready;
  assign in_fire  = in_valid & in_ready;

  generate
    if (DATA_WIDTH <= dq_pkg::WORD_W) begin : g_narrow
      assign push_word   = in_push_value[DATA_WIDTH-1:0];
      if (DATA_WIDTH < dq_pkg::WORD_W) begin : g_pad
        assign pop_value_c = {{(dq_pkg::WORD_W - DATA_WIDTH){1'b0}}, pop_word};
      end else begin : g_same
        assign pop_value_c = pop_word;
      end
    end else begin : g_wide
      assign push_word   = {{(DATA_WIDTH - dq_pkg::WORD_W){1'b0}}, in_push_value};
      assign pop_value_c = pop_word[dq_pkg::WORD_W-1:0];
    end

    if (CNT_W >= dq_pkg::OCC_W) begin : g_occ_cut
      assign occ_c = count_nxt[dq_pkg::OCC_W-1:0];
    end else begin : g_occ_pad
      assign occ_c = {{(dq_pkg::OCC_W - CNT_W){1'b0}}, count_nxt};
    end
  endgenerate

  assign empty = ~cell_occ[0];
  assign full  = cell_occ[DEPTH-1];

  always_comb begin
    status_c = dq_pkg::ST_OK;
    ctl      = '0;
    unique case (in_command)
      dq_pkg::CMD_PUSH_FRONT: begin
        if (full) status_c = dq_pkg::ST_FULL;
        else      ctl.push_front = in_fire;
      end
      dq_pkg::CMD_PUSH_BACK: begin
        if (full) status_c = dq_pkg::ST_FULL;
        else      ctl.push_back = in_fire;
      end
      dq_pkg::CMD_POP_FRONT: begin
        if (empty) status_c = dq_pkg::ST_EMPTY;
        else       ctl.pop_front = in_fire;
      end
      dq_pkg::CMD_POP_BACK: begin
        if (empty) status_c = dq_pkg::ST_EMPTY;
        else       ctl.pop_back = in_fire;
      end
      default: status_c = dq_pkg::ST_OK;
    endcase
  end

  // the tail flag is one-hot over the occupied cells
  always_comb begin
    tail_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_word = tail_word | (cell_data[i] & {DATA_WIDTH{cell_tail[i]}});
    end
  end

  always_comb begin
    pop_word = '0;
    if (ctl.pop_front) pop_word = cell_data[0];
    else if (ctl.pop_back) pop_word = tail_word;
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.push_front || ctl.push_back) count_nxt = count_r + CNT_W'(1);
    else if (ctl.pop_front || ctl.pop_back) count_nxt = count_r - CNT_W'(1);
  end

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic                  left_occ;
      logic [DATA_WIDTH-1:0] right_data;
      logic                  right_occ;

      if (i == 0) begin : g_head
        assign left_data = push_word;
        assign left_occ  = 1'b1;
      end else begin : g_mid_l
        assign left_data = cell_data[i-1];
        assign left_occ  = cell_occ[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign right_data = '0;
        assign right_occ  = 1'b0;
      end else begin : g_mid_r
        assign right_data = cell_data[i+1];
        assign right_occ  = cell_occ[i+1];
      end

      dq_cell #(
        .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .push_word  (push_word),
        .left_data  (left_data),
        .left_occ   (left_occ),
        .right_data (right_data),
        .right_occ  (right_occ),
        .data_o     (cell_data[i]),
        .occ_o      (cell_occ[i]),
        .tail_o     (cell_tail[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_pop_value_r <= pop_value_c;
      out_status_r    <= status_c;
      out_occupancy_r <= occ_c;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pop_value = out_pop_value_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occupancy_r;

  // occupied flags form a prefix whose length is the count
  `DQ_ASSERT_ALWAYS(a_occ_matches_count, $countones(cell_occ) == int'(count_r), "occupied cells disagree with count")
  `DQ_ASSERT_ALWAYS(a_tail_onehot, $onehot0(cell_tail) && (empty == (cell_tail == '0)), "tail flag not unique")
  `DQ_ASSERT_NEXT(a_error_keeps_state, in_fire && (status_c != dq_pkg::ST_OK), $stable(count_r) && $stable(cell_occ), "failed transaction changed state")

endmodule

// ----- bench/tb_double_ended_queue.sv -----
// self-checking testbench for double_ended_queue: directed, then random push/pop
// traffic, with a ring-buffer predictor and an in-order result scoreboard
// depends on dq_pkg and the double_ended_queue rtl
module tb_double_ended_queue;

  localparam int QUEUE_DEPTH = dq_pkg::DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1700;

  typedef struct packed {
    logic [dq_pkg::WORD_W-1:0] pop_value;
    logic [dq_pkg::STAT_W-1:0] status;
    logic [dq_pkg::OCC_W-1:0]  occupancy;
  } dq_result_t;

  // predicts each answer from its own copy of the ring and checks the block in order
  class dq_scoreboard;
    logic [dq_pkg::WORD_W-1:0] ring [QUEUE_DEPTH];
    logic [3:0]                front_idx;
    logic [dq_pkg::OCC_W-1:0]  count;
    dq_result_t                awaited [$];
    int n_mismatch;
    int n_checked;
    int n_full_rejects;
    int n_empty_rejects;
    int peak_count;

    function new();
      front_idx = '0;
      count = '0;
      n_mismatch = 0;
      n_checked = 0;
      n_full_rejects = 0;
      n_empty_rejects = 0;
      peak_count = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_transaction(logic [dq_pkg::CMD_W-1:0] cmd,
                                   logic [dq_pkg::WORD_W-1:0] word);
      dq_result_t r;
      logic [3:0] slot;
      logic [dq_pkg::OCC_W-1:0] back_off;
      r.pop_value = '0;
      r.status = dq_pkg::ST_OK;
      if (cmd == dq_pkg::CMD_PUSH_FRONT || cmd == dq_pkg::CMD_PUSH_BACK) begin
        if (count == QUEUE_DEPTH) begin
          r.status = dq_pkg::ST_FULL;
          n_full_rejects++;
        end else if (cmd == dq_pkg::CMD_PUSH_FRONT) begin
          front_idx = front_idx - 4'd1;
          ring[front_idx] = word;
          count++;
        end else begin
          slot = front_idx + count[3:0];
          ring[slot] = word;
          count++;
        end
      end else begin
        if (count == 0) begin
          r.status = dq_pkg::ST_EMPTY;
          n_empty_rejects++;
        end else if (cmd == dq_pkg::CMD_POP_FRONT) begin
          r.pop_value = ring[front_idx];
          front_idx = front_idx + 4'd1;
          count--;
        end else begin
          back_off = count - 5'd1;
          slot = front_idx + back_off[3:0];
          r.pop_value = ring[slot];
          count--;
        end
      end
      r.occupancy = count;
      if (int'(count) > peak_count) peak_count = int'(count);
      awaited.push_back(r);
    endfunction

    function void check_result(logic [dq_pkg::WORD_W-1:0] pop_value,
                               logic [dq_pkg::STAT_W-1:0] status,
                               logic [dq_pkg::OCC_W-1:0] occupancy);
      dq_result_t exp_r;
      n_checked++;
      if (awaited.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: unexpected result pop_value=%h status=%0d occupancy=%0d",
                   $realtime, pop_value, status, occupancy);
        return;
      end
      exp_r = awaited.pop_front();
      if (pop_value !== exp_r.pop_value || status !== exp_r.status ||
          occupancy !== exp_r.occupancy) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: result %0d mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                   $realtime, n_checked, exp_r.pop_value, exp_r.status, exp_r.occupancy,
                   pop_value, status, occupancy);
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [dq_pkg::CMD_W-1:0]  in_command = dq_pkg::CMD_PUSH_FRONT;
  logic [dq_pkg::WORD_W-1:0] in_push_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [dq_pkg::WORD_W-1:0] out_pop_value;
  logic [dq_pkg::STAT_W-1:0] out_status;
  logic [dq_pkg::OCC_W-1:0]  out_occupancy;

  dq_scoreboard sb = new();
  int n_sent = 0;

  double_ended_queue u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_push_value(in_push_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pop_value(out_pop_value),
    .out_status   (out_status),
    .out_occupancy(out_occupancy)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("tb_double_ended_queue: errors");
    $finish;
  end

  // mostly back-to-back, sometimes a short gap, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [dq_pkg::WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return 32'h1 << $urandom_range(0, dq_pkg::WORD_W - 1);
    return $urandom();
  endfunction

  task automatic send_item(logic [dq_pkg::CMD_W-1:0] cmd, logic [dq_pkg::WORD_W-1:0] word,
                           int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_push_value <= word;
    do @(posedge clk); while (!in_ready);
    sb.note_transaction(cmd, word);
    n_sent++;
  endtask

  // stop sending until every outstanding result has been taken
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    int i;
    send_item(dq_pkg::CMD_POP_FRONT, '1, 0);
    send_item(dq_pkg::CMD_POP_BACK, '0, pick_gap());
    send_item(dq_pkg::CMD_PUSH_FRONT, '0, 0);
    send_item(dq_pkg::CMD_PUSH_BACK, '1, 0);
    send_item(dq_pkg::CMD_POP_FRONT, 32'h5555_5555, pick_gap());
    send_item(dq_pkg::CMD_POP_BACK, 32'hAAAA_AAAA, 0);
    // fill to the brim from both ends, then knock on a full queue
    for (i = 0; i < QUEUE_DEPTH; i++) begin
      if (i[0])
        send_item(dq_pkg::CMD_PUSH_BACK, ~(32'h1 << (2 * i)), pick_gap());
      else
        send_item(dq_pkg::CMD_PUSH_FRONT, 32'h1 << (2 * i + 1), pick_gap());
    end
    send_item(dq_pkg::CMD_PUSH_FRONT, 32'hDEAD_BEEF, 0);
    send_item(dq_pkg::CMD_PUSH_BACK, 32'hFEED_F00D, 0);
  endtask

  // segments lean toward filling, draining or neither so both ends get hit often
  task automatic run_random(int n_items);
    int i;
    int seg_left;
    int mode;
    bit no_gaps;
    int push_pct;
    logic [dq_pkg::CMD_W-1:0] cmd;
    seg_left = 0;
    mode = 0;
    no_gaps = 1'b0;
    for (i = 0; i < n_items; i++) begin
      if (i == n_items / 2) hold_until_drained();
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 60);
        mode = $urandom_range(0, 2);
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      seg_left--;
      push_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
      if ($urandom_range(0, 99) < push_pct)
        cmd = $urandom_range(0, 1) ? dq_pkg::CMD_PUSH_BACK : dq_pkg::CMD_PUSH_FRONT;
      else
        cmd = $urandom_range(0, 1) ? dq_pkg::CMD_POP_BACK : dq_pkg::CMD_POP_FRONT;
      send_item(cmd, pick_word(), no_gaps ? 0 : pick_gap());
    end
  endtask

  // result side back-pressure, with calm stretches where it never stalls
  initial begin
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left = 0;
    forever begin
      @(negedge clk);
      if (calm_left > 0) begin
        calm_left--;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(30, 120);
        else if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_pop_value, out_status, out_occupancy);
  end

  initial begin
    int wait_cycles;
    bit failed;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random(RANDOM_ITEMS);
    @(negedge clk);
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (5) @(posedge clk);
    failed = (sb.n_mismatch != 0) || (sb.pending() != 0);
    if (sb.pending() != 0)
      $display("%0d expected results never arrived", sb.pending());
    $display("run covered %0d transactions and %0d results, occupancy peaked at %0d",
             n_sent, sb.n_checked, sb.peak_count);
    $display("%0d pushes refused on a full queue, %0d pops refused on an empty one, %0d bad",
             sb.n_full_rejects, sb.n_empty_rejects, sb.n_mismatch);
    if (!failed)
      $display("tb_double_ended_queue: clean");
    else
      $display("tb_double_ended_queue: errors");
    $finish;
  end

endmodule
